[hdl/gspc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gspc_pkg
// Shared widths, types, tables and constants of the gas ppm conditioner.
// ---------------------------------------------------------------------------
package gspc_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int TEMP_W     = 16;
  localparam int PPM_W      = 32;
  localparam int LEVEL_W    = 32;
  localparam int GAS_W      = 26;
  localparam int GAIN_W     = 3;
  localparam int MODEL_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int LSB_W   = 15;               // largest LSB is 18750
  localparam int V_W     = 31;               // sample times LSB
  localparam int DIFF_W  = 33;               // voltage minus baseline
  localparam int MAG_W   = 32;               // magnitude of the difference
  localparam int NUM_W   = MAG_W + GAS_W;    // magnitude times gas
  localparam int NUMR_W  = NUM_W + 1;        // plus half the denominator
  localparam int DEN_W   = 32;
  localparam int QUO_W   = 34;               // quotient bits kept, larger saturates
  localparam int HEAD_W  = NUMR_W - QUO_W;   // dividend bits above the quotient
  localparam int CORR_W  = 17;               // correction up to 1.0 in Q16.16
  localparam int QMAG_W  = QUO_W + 1;
  localparam int RES_W   = QUO_W + 2;

  // Temperature correction
  localparam int YP_W     = 24;
  localparam int RECIP_W  = 26;
  localparam int PROD_W   = YP_W + RECIP_W;
  localparam int QC_W     = 17;              // quotient by 125 stays below 2^17
  localparam int REM_W    = 8;
  localparam int COEF_A_W = 7;
  localparam int COEF_B_W = 12;
  localparam int XS_W     = 25;
  localparam int XC_W     = 18;

  localparam logic signed [TEMP_W-1:0] T_PIECE1 = 16'sd6400;   // 25 C
  localparam logic signed [TEMP_W-1:0] T_PIECE2 = 16'sd7680;   // 30 C
  localparam logic signed [TEMP_W-1:0] T_PIECE3 = 16'sd8704;   // 34 C
  localparam logic signed [TEMP_W-1:0] T_PIECE4 = 16'sd9728;   // 38 C
  localparam logic signed [TEMP_W-1:0] T_PIECE5 = 16'sd10496;  // 41 C

  localparam logic [COEF_A_W-1:0] A_PIECE1 = 7'd34;
  localparam logic [COEF_A_W-1:0] A_PIECE2 = 7'd50;
  localparam logic [COEF_A_W-1:0] A_PIECE3 = 7'd95;
  localparam logic [COEF_A_W-1:0] A_PIECE4 = 7'd100;
  localparam logic [COEF_B_W-1:0] B_PIECE1 = 12'd826;
  localparam logic [COEF_B_W-1:0] B_PIECE2 = 12'd1356;
  localparam logic [COEF_B_W-1:0] B_PIECE3 = 12'd2892;
  localparam logic [COEF_B_W-1:0] B_PIECE4 = 12'd3100;

  // (256x + 500) / 1000 == (32x + 62) / 125, reciprocal floor(2^32 / 125)
  localparam logic [YP_W-1:0]    YP_BIAS   = 24'd62;
  localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359738;
  localparam logic [REM_W-1:0]   DIV_125   = 8'd125;
  localparam int                 RECIP_SH  = 32;
  localparam logic [CORR_W-1:0]  CORR_FULL = 17'd65536;

  // Filter thresholds and replacement values, Q16.16
  localparam logic signed [RES_W-1:0] FLT_POS  = 36'sd13108;
  localparam logic signed [RES_W-1:0] FLT_N05  = -36'sd32768;
  localparam logic signed [RES_W-1:0] FLT_N1   = -36'sd65536;
  localparam logic signed [RES_W-1:0] FLT_N5   = -36'sd327680;
  localparam logic signed [RES_W-1:0] FLT_N10  = -36'sd655360;
  localparam logic signed [RES_W-1:0] FLT_N30  = -36'sd1966080;
  localparam logic [PPM_W-1:0] FLT_V002 = 32'd1311;
  localparam logic [PPM_W-1:0] FLT_V003 = 32'd1966;
  localparam logic [PPM_W-1:0] FLT_V004 = 32'd2621;
  localparam logic [PPM_W-1:0] FLT_V005 = 32'd3277;
  localparam logic [PPM_W-1:0] FLT_V006 = 32'd3932;

  localparam logic signed [RES_W-1:0] PPM_MAX_R = 36'sd2147483647;
  localparam logic signed [RES_W-1:0] PPM_MIN_R = -36'sd2147483648;
  localparam logic [PPM_W-1:0] PPM_MAX_V = 32'h7FFF_FFFF;
  localparam logic [PPM_W-1:0] PPM_MIN_V = 32'h8000_0000;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 3'd2;
  localparam logic [MODEL_W-1:0] MODEL_NH3 = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_CODE    = 3'd0,
    REG_SENS_TYPE    = 3'd1,
    REG_SPAN         = 3'd2,
    REG_BASELINE     = 3'd3,
    REG_CAL_GAS      = 3'd4,
    REG_FILTER_EN    = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    CORR_ZERO,
    CORR_LINE,
    CORR_ONE
  } corr_mode_e;

  // Settled configuration, seen by the front and back ends
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_code;
    logic [MODEL_W-1:0] sens_type;
    logic [LEVEL_W-1:0] baseline;
    logic [GAS_W-1:0]   cal_gas;
    logic               filter_en;
    logic [DEN_W-1:0]   den;
    logic               cal_bad;
  } cfg_t;

  // Front end to divider
  typedef struct packed {
    logic              neg;
    logic [NUMR_W-1:0] numr;
    logic [CORR_W-1:0] corr;
  } front_t;

  // Divider to back end
  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic [QUO_W-1:0]  quo;
    logic [CORR_W-1:0] corr;
  } quot_t;

  // Finished result
  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic             invalid;
  } res_t;

  // LSB size in hundredths of a microvolt per gain code
  function automatic logic [LSB_W-1:0] lsb_lookup(input logic [GAIN_W-1:0] code);
    logic [LSB_W-1:0] lsb;
    case (code)
      3'd0:    lsb = 15'd18750;
      3'd1:    lsb = 15'd12500;
      3'd2:    lsb = 15'd6250;
      3'd3:    lsb = 15'd3125;
      3'd4:    lsb = 15'd1562;
      3'd5:    lsb = 15'd781;
      default: lsb = 15'd6250;
    endcase
    return lsb;
  endfunction

endpackage

[hdl/gas_sensor_ppm_conditioner.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gas_sensor_ppm_conditioner
// Converts gas ADC samples and temperature into a calibrated ppm value.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one gas sample and one
//   Q8.8 temperature per transfer; output channel (out_valid_o/out_ready_i)
//   returns one Q16.16 ppm value and the calibration-invalid flag.
//   The user writes configuration through cfg_we_i/cfg_index_i/cfg_data_i,
//   one register per cycle, only while no samples are in flight; unenforced.
//   An input transfer passes through 6 front-end stages, a divider setup
//   stage and 34 quotient-bit stages, 3 back-end stages and the output
//   register. Throughput is one sample per cycle while the skid register
//   is empty, set by the fully pipelined divider.
//   Reset empties the pipeline and loads the register defaults (gain code
//   2, NH3 model, zero levels and gas, filter off).
//   When the receiver stalls, a skid register catches one more result; the
//   pipeline and in_ready_o then hold until the skid register drains.
// ---------------------------------------------------------------------------
module gas_sensor_ppm_conditioner
  import gspc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   gas_sample_i,
  input  logic [TEMP_W-1:0]     temperature_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PPM_W-1:0]      gas_ppm_o,
  output logic                  calibration_invalid_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [GAIN_W-1:0]  gain_code_q;
  logic [MODEL_W-1:0] sens_type_q;
  logic [LEVEL_W-1:0] span_q;
  logic [LEVEL_W-1:0] baseline_q;
  logic [GAS_W-1:0]   cal_gas_q;
  logic               filter_en_q;
  logic [DEN_W-1:0]   den_q;
  logic               cal_bad_q;
  logic [LEVEL_W:0]   den_d;
  cfg_t               cfg;

  // Pipeline and output side
  logic   en;
  logic   front_vld;
  front_t front_data;
  logic   div_vld;
  quot_t  div_data;
  logic   back_vld;
  res_t   back_data;
  logic   out_vld_q;
  res_t   out_q;
  logic   skid_vld_q;
  res_t   skid_q;
  logic   take;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_code_q    <= GAIN_RST;
      sens_type_q    <= MODEL_NH3;
      span_q         <= '0;
      baseline_q     <= '0;
      cal_gas_q      <= '0;
      filter_en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GAIN_CODE:    gain_code_q    <= cfg_data_i[GAIN_W-1:0];
        REG_SENS_TYPE:    sens_type_q    <= cfg_data_i[MODEL_W-1:0];
        REG_SPAN:         span_q         <= cfg_data_i[LEVEL_W-1:0];
        REG_BASELINE:     baseline_q     <= cfg_data_i[LEVEL_W-1:0];
        REG_CAL_GAS:      cal_gas_q      <= cfg_data_i[GAS_W-1:0];
        REG_FILTER_EN:    filter_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Derive denominator and validity once from the levels
  assign den_d = {span_q[LEVEL_W-1], span_q} - {baseline_q[LEVEL_W-1], baseline_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q     <= '0;
      cal_bad_q <= 1'b1;
    end else begin
      den_q     <= den_d[DEN_W-1:0];
      cal_bad_q <= ($signed(span_q) <= $signed(baseline_q));
    end
  end

  always_comb begin
    cfg.gain_code    = gain_code_q;
    cfg.sens_type    = sens_type_q;
    cfg.baseline     = baseline_q;
    cfg.cal_gas      = cal_gas_q;
    cfg.filter_en    = filter_en_q;
    cfg.den          = den_q;
    cfg.cal_bad      = cal_bad_q;
  end

  // Advance the whole pipeline while the skid register is empty
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  gspc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .in_valid_i    (in_valid_i),
    .gas_sample_i  (gas_sample_i),
    .temperature_i (temperature_i),
    .cfg_i         (cfg),
    .valid_o       (front_vld),
    .data_o        (front_data)
  );

  gspc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_vld),
    .data_i  (front_data),
    .den_i   (den_q),
    .valid_o (div_vld),
    .data_o  (div_data)
  );

  gspc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .data_i  (div_data),
    .cfg_i   (cfg),
    .valid_o (back_vld),
    .data_o  (back_data)
  );

  // Output register and skid register
  assign take = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (back_vld) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (back_vld) begin
      if (!out_vld_q || take) begin
        out_q <= back_data;
      end else begin
        skid_q <= back_data;
      end
    end
  end

  assign out_valid_o           = out_vld_q;
  assign gas_ppm_o             = out_q.ppm;
  assign calibration_invalid_o = out_q.invalid;

endmodule

[hdl/gspc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gspc_front
// Six-stage front end: voltage scaling, baseline offset, magnitude, product
// with the calibration gas and rounding bias, temperature correction alongside.
// ---------------------------------------------------------------------------
module gspc_front
  import gspc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  logic [SAMPLE_W-1:0] gas_sample_i,
  input  logic [TEMP_W-1:0]   temperature_i,
  input  cfg_t                cfg_i,
  output logic                valid_o,
  output front_t              data_o
);

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld_q;

  // stage 1
  logic [SAMPLE_W-1:0] smp_q;
  logic [TEMP_W-1:0]   tmp_q;
  // stage 2
  logic [V_W-1:0]  v_q;
  logic [YP_W-1:0] yp2_q;
  corr_mode_e      mode2_q;
  // stage 3
  logic [DIFF_W-1:0] d_q;
  logic [PROD_W-1:0] prod_q;
  logic [YP_W-1:0]   yp3_q;
  corr_mode_e        mode3_q;
  // stage 4
  logic              neg4_q;
  logic [MAG_W-1:0]  mag_q;
  logic [QC_W-1:0]   qc_q;
  logic [REM_W-1:0]  rm_q;
  corr_mode_e        mode4_q;
  // stage 5
  logic              neg5_q;
  logic [NUM_W-1:0]  num_q;
  logic [CORR_W-1:0] corr5_q;
  // stage 6
  logic              neg6_q;
  logic [NUMR_W-1:0] numr_q;
  logic [CORR_W-1:0] corr6_q;

  // stage 2 logic
  logic signed [2*SAMPLE_W-1:0]        v_full;
  logic [COEF_A_W-1:0]                 coef_a;
  logic [COEF_B_W-1:0]                 coef_b;
  corr_mode_e                          mode_d;
  logic signed [COEF_A_W+TEMP_W:0]     at_s;
  logic signed [XS_W-1:0]              x_s;
  logic [XC_W-1:0]                     x_c;
  logic [YP_W-1:0]                     yp_d;
  // stage 3 logic
  logic signed [DIFF_W-1:0]            d_d;
  logic [PROD_W-1:0]                   prod_d;
  // stage 4 logic
  logic [DIFF_W-1:0]                   mag_full;
  logic [QC_W-1:0]                     qc_d;
  logic [YP_W:0]                       mul125;
  logic [YP_W-1:0]                     rm_full;
  // stage 5 logic
  logic [CORR_W-1:0]                   corr_d;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  // Scale the sample, pick the correction piece and form 32x + 62 of the linear piece
  always_comb begin
    v_full = $signed(smp_q) * $signed({1'b0, lsb_lookup(cfg_i.gain_code)});
    coef_a = A_PIECE1;
    coef_b = B_PIECE1;
    mode_d = CORR_ZERO;
    if (cfg_i.sens_type == MODEL_NH3) begin
      if ($signed(tmp_q) >= T_PIECE5) begin
        mode_d = CORR_ONE;
      end else if ($signed(tmp_q) >= T_PIECE4) begin
        coef_a = A_PIECE4;
        coef_b = B_PIECE4;
        mode_d = CORR_LINE;
      end else if ($signed(tmp_q) >= T_PIECE3) begin
        coef_a = A_PIECE3;
        coef_b = B_PIECE3;
        mode_d = CORR_LINE;
      end else if ($signed(tmp_q) >= T_PIECE2) begin
        coef_a = A_PIECE2;
        coef_b = B_PIECE2;
        mode_d = CORR_LINE;
      end else if ($signed(tmp_q) >= T_PIECE1) begin
        coef_a = A_PIECE1;
        coef_b = B_PIECE1;
        mode_d = CORR_LINE;
      end
    end
    at_s = $signed({1'b0, coef_a}) * $signed(tmp_q);
    x_s  = XS_W'(at_s) - $signed({{(XS_W-COEF_B_W-8){1'b0}}, coef_b, 8'd0});
    x_c  = x_s[XS_W-1] ? '0 : x_s[XC_W-1:0];
    yp_d = {1'b0, x_c, 5'd0} + YP_BIAS;
  end

  // Offset from baseline and reciprocal product
  always_comb begin
    d_d    = $signed({{(DIFF_W-V_W){v_q[V_W-1]}}, v_q})
           - $signed({cfg_i.baseline[LEVEL_W-1], cfg_i.baseline});
    prod_d = PROD_W'(yp2_q) * PROD_W'(RECIP_125);
  end

  // Magnitude, and remainder of the estimated quotient by 125
  always_comb begin
    mag_full = d_q[DIFF_W-1] ? (DIFF_W'(0) - d_q) : d_q;
    qc_d     = prod_q[RECIP_SH +: QC_W];
    mul125   = {1'b0, qc_d, 7'd0} - {7'd0, qc_d, 1'b0} - {8'd0, qc_d};
    rm_full  = yp3_q - mul125[YP_W-1:0];
  end

  // Correct the quotient estimate by one and select the correction
  always_comb begin
    case (mode4_q)
      CORR_LINE: corr_d = qc_q + {{(CORR_W-1){1'b0}}, (rm_q >= DIV_125)};
      CORR_ONE:  corr_d = CORR_FULL;
      default:   corr_d = '0;
    endcase
  end

  // Pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      smp_q   <= gas_sample_i;
      tmp_q   <= temperature_i;

      v_q     <= v_full[V_W-1:0];
      yp2_q   <= yp_d;
      mode2_q <= mode_d;

      d_q     <= d_d;
      prod_q  <= prod_d;
      yp3_q   <= yp2_q;
      mode3_q <= mode2_q;

      neg4_q  <= d_q[DIFF_W-1];
      mag_q   <= mag_full[MAG_W-1:0];
      qc_q    <= qc_d;
      rm_q    <= rm_full[REM_W-1:0];
      mode4_q <= mode3_q;

      neg5_q  <= neg4_q;
      num_q   <= NUM_W'(mag_q) * NUM_W'(cfg_i.cal_gas);
      corr5_q <= corr_d;

      neg6_q  <= neg5_q;
      numr_q  <= NUMR_W'(num_q) + NUMR_W'(cfg_i.den[DEN_W-1:1]);
      corr6_q <= corr5_q;
    end
  end

  assign valid_o      = vld_q[STAGES-1];
  assign data_o.neg   = neg6_q;
  assign data_o.numr  = numr_q;
  assign data_o.corr  = corr6_q;

endmodule

[hdl/gspc_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gspc_div
// Pipelined restoring divider: one setup stage with an overflow check,
// then one quotient bit per stage.
// ---------------------------------------------------------------------------
module gspc_div
  import gspc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  front_t           data_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output quot_t            data_o
);

  localparam int STEPS = QUO_W;

  logic [STEPS:0]    vld_q;
  logic [DEN_W-1:0]  rem_q  [0:STEPS];
  logic [QUO_W-1:0]  lq_q   [0:STEPS];
  logic              neg_q  [0:STEPS];
  logic              ovf_q  [0:STEPS];
  logic [CORR_W-1:0] corr_q [0:STEPS];

  logic [DEN_W-1:0]  head;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STEPS-1:0], valid_i};
    end
  end

  // Setup: a quotient of 2^QUO_W or more only ever saturates
  assign head = {{(DEN_W-HEAD_W){1'b0}}, data_i.numr[NUMR_W-1:QUO_W]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= head;
      lq_q[0]   <= data_i.numr[QUO_W-1:0];
      neg_q[0]  <= data_i.neg;
      ovf_q[0]  <= (head >= den_i);
      corr_q[0] <= data_i.corr;
    end
  end

  // One shift, compare and subtract per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      trial = {rem_q[k-1], lq_q[k-1][QUO_W-1]};
      diff  = trial - {1'b0, den_i};
      ge    = (trial >= {1'b0, den_i});
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lq_q[k]   <= {lq_q[k-1][QUO_W-2:0], ge};
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        corr_q[k] <= corr_q[k-1];
      end
    end
  end

  assign valid_o     = vld_q[STEPS];
  assign data_o.neg  = neg_q[STEPS];
  assign data_o.ovf  = ovf_q[STEPS];
  assign data_o.quo  = lq_q[STEPS];
  assign data_o.corr = corr_q[STEPS];

endmodule

[hdl/gspc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gspc_back
// Three-stage back end: sign restore, correction subtract, then filter,
// saturation and the invalid-calibration override.
// ---------------------------------------------------------------------------
module gspc_back
  import gspc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  quot_t data_i,
  input  cfg_t  cfg_i,
  output logic  valid_o,
  output res_t  data_o
);

  localparam int STAGES = 3;

  logic [STAGES-1:0] vld_q;
  logic [RES_W-1:0]  q_q;
  logic [CORR_W-1:0] corr_q;
  logic [RES_W-1:0]  res_q;
  res_t              out_q;

  logic [QMAG_W-1:0] qmag;
  logic [RES_W-1:0]  q_d;
  logic [RES_W-1:0]  res_d;
  logic [RES_W-1:0]  flt;
  logic [PPM_W-1:0]  ppm_d;
  logic              flt_sub;
  logic [PPM_W-1:0]  flt_val;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  // Restore the sign, clipping an overflowed quotient to 2^QUO_W
  always_comb begin
    qmag = data_i.ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, data_i.quo};
    q_d  = data_i.neg ? (RES_W'(0) - RES_W'(qmag)) : RES_W'(qmag);
  end

  // Subtract the temperature correction
  assign res_d = q_q - RES_W'(corr_q);

  // Remap small and negative results when the filter is enabled, then saturate
  always_comb begin
    flt_sub = 1'b0;
    flt_val = '0;
    if (cfg_i.filter_en) begin
      if ($signed(res_q) >= FLT_POS) begin
        flt_sub = 1'b0;
      end else if ($signed(res_q) >= FLT_N05) begin
        flt_sub = 1'b1;
        flt_val = '0;
      end else if ($signed(res_q) >= FLT_N1) begin
        flt_sub = 1'b1;
        flt_val = FLT_V002;
      end else if ($signed(res_q) >= FLT_N5) begin
        flt_sub = 1'b1;
        flt_val = FLT_V003;
      end else if ($signed(res_q) >= FLT_N10) begin
        flt_sub = 1'b1;
        flt_val = FLT_V004;
      end else if ($signed(res_q) >= FLT_N30) begin
        flt_sub = 1'b1;
        flt_val = FLT_V005;
      end else begin
        flt_sub = 1'b1;
        flt_val = FLT_V006;
      end
    end
    flt = flt_sub ? RES_W'(flt_val) : res_q;
    if ($signed(flt) > PPM_MAX_R) begin
      ppm_d = PPM_MAX_V;
    end else if ($signed(flt) < PPM_MIN_R) begin
      ppm_d = PPM_MIN_V;
    end else begin
      ppm_d = flt[PPM_W-1:0];
    end
  end

  // Pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q           <= q_d;
      corr_q        <= data_i.corr;
      res_q         <= res_d;
      out_q.ppm     <= cfg_i.cal_bad ? '0 : ppm_d;
      out_q.invalid <= cfg_i.cal_bad;
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign data_o  = out_q;

endmodule
